### rtl/maf_pkg.sv
// Shared widths and constants for the moving average filter.
// No dependencies; the filter top level imports this package.
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 16;
    localparam int AVG_W     = 16;
    localparam int COUNT_W   = 8;
    localparam int SUM_W     = 24;

    // Sample store geometry.
    localparam int MAX_WINDOW = 256;
    localparam int IDX_W      = $clog2(MAX_WINDOW);

    // Divider step counter width.
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Packed stream widths (whole bytes).
    localparam int S_TDATA_W = SAMPLE_W;
    localparam int M_TDATA_W = AVG_W + COUNT_W;

    // Window length after reset.
    localparam logic [COUNT_W-1:0] WINDOW_RESET = COUNT_W'(8);

endpackage : maf_pkg

`default_nettype wire

### rtl/moving_average_filter.sv
// Moving average filter top level: sample ring memory, running sum and
// a radix-2 restoring divider. Depends on maf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted sample produces one item holding the truncated mean of the
// last window_length samples and the number of samples currently averaged.
// Before the window has filled, the mean is taken over the samples seen so
// far. Each accepted sample passes through the ring memory read, the sum
// update and write-back, a bit-serial divide of the 24-bit sum by the 8-bit
// count and the load of the output register before the next sample can be
// accepted. The output register lets a finished item wait while the next
// sample is taken in; if the previous item is still not taken when a new
// quotient is ready, the filter stalls. Writing window_length restarts
// warm-up; a value of zero acts as one.
module moving_average_filter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration: window_length.
    input  wire logic                          cfg_we,
    input  wire logic [maf_pkg::COUNT_W-1:0]   cfg_wdata,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [maf_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] sample
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [maf_pkg::M_TDATA_W-1:0]      m_tdata    // [15:0] average,
                                                          // [23:16] samples_in_window
);
    import maf_pkg::*;

    // State codes.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [COUNT_W-1:0]    wlen_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]      sum_reg;

    logic [SAMPLE_W-1:0]   mem [0:MAX_WINDOW-1];
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic [SAMPLE_W-1:0]   sample_reg;

    logic [SUM_W-1:0]      quo_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [COUNT_W-1:0]    div_reg;
    logic [DIV_CNT_W-1:0]  step_reg;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    logic [COUNT_W-1:0]    win;
    logic                  full;
    logic [SUM_W-1:0]      old_ext;
    logic [SUM_W-1:0]      sum_next;
    logic [COUNT_W-1:0]    count_next;
    logic [IDX_W-1:0]      idx_next;
    logic [COUNT_W:0]      rem_shift;
    logic                  q_bit;
    logic                  accept;
    logic                  load_out;

    // Effective window: zero acts as one.
    assign win    = (wlen_reg == '0) ? COUNT_W'(1) : wlen_reg;
    assign full   = (count_reg == win);
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Running sum and ring bookkeeping for the sample in flight.
    always_comb
    begin
        old_ext    = full ? SUM_W'(rd_data_reg) : '0;
        sum_next   = sum_reg + SUM_W'(sample_reg) - old_ext;
        count_next = full ? count_reg : count_reg + COUNT_W'(1);
        if ((COUNT_W + 1)'(idx_reg) + (COUNT_W + 1)'(1) == (COUNT_W + 1)'(win))
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // One restoring divide step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        q_bit     = (rem_shift >= {1'b0, div_reg});
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and filter state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= WINDOW_RESET;
            idx_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                wlen_reg  <= cfg_wdata;
                idx_reg   <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                idx_reg   <= idx_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
            if (state_reg == ST_UPDATE)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + DIV_CNT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample ring memory: read on acceptance, write back during the update.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (state_reg == ST_UPDATE)
        begin
            mem[idx_reg] <= sample_reg;
        end
    end

    // Datapath registers: captured sample, divider and output item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (state_reg == ST_UPDATE)
        begin
            quo_reg <= sum_next;
            rem_reg <= '0;
            div_reg <= count_next;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], q_bit};
            if (q_bit)
            begin
                rem_reg <= COUNT_W'(rem_shift - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= rem_shift[COUNT_W-1:0];
            end
        end
        if (load_out)
        begin
            out_data_reg <= {count_reg, quo_reg[AVG_W-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : moving_average_filter

`default_nettype wire

### verif/moving_average_filter_test.sv
// Self-checking testbench for moving_average_filter: a scoreboard class that
// predicts each windowed mean, plus tasks that drive samples and window writes.
// Depends on maf_pkg and the moving_average_filter RTL.
`timescale 1ns / 1ps

module moving_average_filter_test;

    import maf_pkg::*;

    // Cycles from sample acceptance to the next possible acceptance.
    localparam int ITEM_CYCLES   = 27;
    // Cycles with no accepted item, config write or result before giving up.
    localparam int STALL_LIMIT   = 3000;
    localparam int STORE_DEPTH   = 256;

    typedef struct packed {
        logic [COUNT_W-1:0] in_window;
        logic [AVG_W-1:0]   average;
    } mean_result_t;

    // Predicts the filter output for every accepted sample and checks
    // results in arrival order.
    class mean_scoreboard;
        logic [SAMPLE_W-1:0] ring [STORE_DEPTH];
        int                  wr_pos;
        int                  fill;
        logic [SUM_W-1:0]    acc;
        logic [COUNT_W-1:0]  win_len;
        mean_result_t        expected_means [$];
        int                  errors;
        int                  checked;
        int                  accepted;
        int                  windows_used;

        function new();
            win_len      = WINDOW_RESET;
            wr_pos       = 0;
            fill         = 0;
            acc          = '0;
            errors       = 0;
            checked      = 0;
            accepted     = 0;
            windows_used = 1;
        endfunction

        // A window write restarts warm-up.
        function void restart(logic [COUNT_W-1:0] w);
            win_len = w;
            wr_pos  = 0;
            fill    = 0;
            acc     = '0;
            windows_used++;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        // Called for each accepted sample: update the window and queue the mean.
        function void note_sample(logic [SAMPLE_W-1:0] s);
            int               span;
            int               slot;
            int               divisor;
            logic [SUM_W-1:0] leaving;
            mean_result_t     r;
            // A zero window length behaves as a window of one.
            span = (win_len == 0) ? 1 : int'(win_len);
            slot = wr_pos % span;
            leaving = '0;
            if (fill < span) begin
                fill++;
                divisor = fill;
            end
            else begin
                leaving = SUM_W'(ring[slot]);
                divisor = span;
            end
            ring[slot] = s;
            acc = acc + SUM_W'(s) - leaving;
            r.average   = AVG_W'(acc / SUM_W'(divisor));
            r.in_window = COUNT_W'(fill);
            expected_means.push_back(r);
            wr_pos = (slot + 1) % span;
            accepted++;
        endfunction

        // Called for each accepted result.
        function void check_result(logic [M_TDATA_W-1:0] data);
            mean_result_t want;
            mean_result_t got;
            got = mean_result_t'(data);
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected result, actual average=%0d in_window=%0d",
                         $time, got.average, got.in_window);
                errors++;
                return;
            end
            want = expected_means.pop_front();
            checked++;
            if (got.average !== want.average) begin
                $display("%0t: average mismatch, expected %0d, actual %0d",
                         $time, want.average, got.average);
                errors++;
            end
            if (got.in_window !== want.in_window) begin
                $display("%0t: samples_in_window mismatch, expected %0d, actual %0d",
                         $time, want.in_window, got.in_window);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [COUNT_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    mean_scoreboard sb = new();

    moving_average_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitor both streams at the clock edge.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
        if (s_tvalid && s_tready)
        begin
            sb.note_sample(s_tdata[SAMPLE_W-1:0]);
        end
    end

    // Receiver: switches between always ready, a rotating stall pattern,
    // sparse readiness and one long stall.
    int                ready_mode  = 0;
    int                mode_left   = 0;
    logic [15:0]       stall_pattern = 16'hA5C3;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode    <= $urandom_range(0, 3);
            mode_left     <= $urandom_range(20, 300);
            stall_pattern <= 16'($urandom);
        end
        else
        begin
            mode_left     <= mode_left - 1;
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= stall_pattern[0];
                2: m_tready <= ($urandom_range(0, 15) == 0);
                default: m_tready <= (mode_left > 80);
            endcase
        end
    end

    // Watchdog on cycles where nothing moves.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Random values with extremes mixed in, full-scale values weighted so long windows
    // push the running sum toward its top.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2: return '1;
            3:       return '0;
            4:       return SAMPLE_W'($urandom_range(0, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one sample and hold it until the filter takes it.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending and wait for every queued mean, then let the pipeline settle.
    // Waiting for a clock edge first lets the monitor log the last accepted sample.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (ITEM_CYCLES + 5) @(posedge clk);
    endtask

    task automatic set_window(input logic [COUNT_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.restart(w);
    endtask

    // Random samples in bursts with random gaps; now and then the sender
    // waits for every result before going on.
    task automatic run_bursts(input int n_items);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 16);
            if (burst > n_items - sent)
                burst = n_items - sent;
            repeat (burst)
            begin
                send_sample(pick_sample());
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if ($urandom_range(0, 19) == 0)
            begin
                drain();
            end
            else if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        drain();
    endtask

    logic [SAMPLE_W-1:0] edge_samples [13] = '{
        16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA
    };
    logic [SAMPLE_W-1:0] unit_samples [3] = '{16'hFFFF, 16'h0000, 16'h1234};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of eight: warm-up, wrap-around and sample extremes.
        foreach (edge_samples[i])
            send_sample(edge_samples[i]);
        drain();

        // A zero window length behaves as one.
        set_window('0);
        foreach (unit_samples[i])
            send_sample(unit_samples[i]);
        drain();

        // Longest window, held long past warm-up with full-scale data weighted in.
        set_window(8'd255);
        run_bursts(320);
        set_window(8'd1);
        run_bursts(30);
        set_window(8'd2);
        run_bursts(30);
        set_window('0);
        run_bursts(20);
        set_window(8'd128);
        run_bursts(40);
        set_window(COUNT_W'($urandom_range(3, 254)));
        run_bursts(40);
        set_window(COUNT_W'($urandom_range(3, 254)));
        run_bursts(40);

        $display("Covered %0d samples and %0d checked means over %0d window settings,",
                 sb.accepted, sb.checked, sb.windows_used);
        $display("including a zero window, a window of 255 and receiver backpressure.");
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
